// File: src/qrmm_pkg.sv
// Shared types, constants and helper functions of the quadrotor motor mixer.
`default_nettype none
package qrmm_pkg;

    localparam int MOTORS = 4;
    localparam int DUTY_W = 17;
    localparam int CMD_W = 16;
    localparam int HEIGHT_W = 8;
    localparam int SUM_W = 38;
    localparam int RAD_W = 48;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W = ROOT_W + 2;
    localparam int SQ_STAGES = ROOT_W / 2;
    localparam int QUOT_W = 19;

    localparam logic signed [14:0] TILT_COEF = 15'sd10240;
    localparam logic signed [18:0] YAW_COEF = 19'sd163061;
    localparam logic signed [26:0] THRUST_COEF = 27'sd20422816;
    localparam logic signed [11:0] HEIGHT_SCALE = 12'sd10;
    localparam logic signed [11:0] GRAV_TENTHS = 12'sd98;
    localparam logic [13:0] DUTY_NUM = 14'd15625;
    localparam logic [24:0] RECIP_49 = 25'd21913098;
    localparam int RECIP_SHIFT = 30;
    localparam logic [23:0] ROOT_DIV = 24'd49;

    localparam logic [DUTY_W-1:0] DUTY_MIN_RST = 17'd60000;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST = 17'd90000;
    localparam logic [DUTY_W-1:0] TRIM_ONE_RST = 17'd53000;
    localparam logic [DUTY_W-1:0] TRIM_TWO_RST = 17'd53000;
    localparam logic [DUTY_W-1:0] TRIM_THREE_RST = 17'd52800;
    localparam logic [DUTY_W-1:0] TRIM_FOUR_RST = 17'd53000;

    typedef enum logic [2:0] {
        REG_DUTY_MIN      = 3'd0,
        REG_DUTY_MAX      = 3'd1,
        REG_YAW_ENABLE    = 3'd2,
        REG_HEIGHT_ENABLE = 3'd3,
        REG_TRIM_ONE      = 3'd4,
        REG_TRIM_TWO      = 3'd5,
        REG_TRIM_THREE    = 3'd6,
        REG_TRIM_FOUR     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_command;
        logic signed [CMD_W-1:0]    yaw_command;
        logic signed [CMD_W-1:0]    pitch_command;
        logic signed [CMD_W-1:0]    roll_command;
    } cmd_t;

    typedef logic [MOTORS-1:0][RAD_W-1:0] rad_vec_t;
    typedef logic [MOTORS-1:0][ROOT_W-1:0] root_vec_t;
    typedef logic [MOTORS-1:0][DUTY_W-1:0] duty_vec_t;

    typedef struct packed {
        logic [MOTORS-1:0]  clamped_mask;
        duty_vec_t          duty;
    } result_t;

    typedef struct packed {
        rad_vec_t                         x;
        logic [MOTORS-1:0][REM_W-1:0]     rem;
        root_vec_t                        root;
    } sq_stage_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_digit_t;

    // One restoring square-root digit: bring down two radicand bits and
    // try to subtract 4*root+1.
    function automatic sq_digit_t sqrt_digit(input logic [REM_W-1:0] rem,
                                             input logic [ROOT_W-1:0] root,
                                             input logic [1:0] pair);
        logic [REM_W+1:0] cand;
        logic [REM_W+1:0] trial;
        sq_digit_t        res;
        cand = {rem, pair};
        trial = {2'b00, root, 2'b01};
        if (cand >= trial) begin
            res.rem = REM_W'(cand - trial);
            res.root = {root[ROOT_W-2:0], 1'b1};
        end
        else begin
            res.rem = REM_W'(cand);
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: src/qrmm_mix.sv
// Torque, thrust and X-frame mixing stages that form one scaled radicand per motor.
`default_nettype none
module qrmm_mix
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           yaw_enable,
    input  wire logic           height_enable,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire qrmm_pkg::cmd_t in_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output qrmm_pkg::rad_vec_t  out_x
);

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    logic signed [qrmm_pkg::SUM_W-1:0] roll_reg, pitch_reg, yaw_reg, thr_reg;
    logic signed [qrmm_pkg::SUM_W-1:0] roll_next, pitch_next, yaw_next, thr_next;
    logic signed [11:0]                hterm;
    logic signed [qrmm_pkg::SUM_W-1:0] n_reg [qrmm_pkg::MOTORS];
    logic signed [qrmm_pkg::SUM_W-1:0] n_next [qrmm_pkg::MOTORS];
    qrmm_pkg::rad_vec_t                x_reg, x_next;

    assign r3 = !v3_reg || out_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;
    assign out_valid = v3_reg;
    assign out_x = x_reg;

    // Stage one: torques and thrust.
    always_comb
    begin
        hterm = height_enable
              ? {{4{in_cmd.height_command[7]}}, in_cmd.height_command}
                * qrmm_pkg::HEIGHT_SCALE + qrmm_pkg::GRAV_TENTHS
              : qrmm_pkg::GRAV_TENTHS;
        roll_next = in_cmd.roll_command * qrmm_pkg::TILT_COEF;
        pitch_next = in_cmd.pitch_command * qrmm_pkg::TILT_COEF;
        // Kept as two branches so the yaw product stays signed.
        if (yaw_enable)
            yaw_next = in_cmd.yaw_command * qrmm_pkg::YAW_COEF;
        else
            yaw_next = '0;
        thr_next = hterm * qrmm_pkg::THRUST_COEF;
    end

    // Stage two: X-frame mixing matrix.
    always_comb
    begin
        n_next[0] = thr_reg + roll_reg + pitch_reg + yaw_reg;
        n_next[1] = thr_reg + roll_reg - pitch_reg - yaw_reg;
        n_next[2] = thr_reg - roll_reg - pitch_reg + yaw_reg;
        n_next[3] = thr_reg - roll_reg + pitch_reg - yaw_reg;
    end

    // Stage three: a radicand at or below zero gives a zero root; the
    // duty scale is folded in as N*15625/16, leaving a divide by 49 after the root.
    always_comb
    begin
        for (int i = 0; i < qrmm_pkg::MOTORS; i++)
        begin
            logic [48:0] prod;
            prod = {14'd0, n_reg[i][34:0]} * {35'd0, qrmm_pkg::DUTY_NUM};
            if (n_reg[i][qrmm_pkg::SUM_W-1] || n_reg[i] == '0)
            begin
                x_next[i] = '0;
            end
            else
            begin
                x_next[i] = {3'd0, prod[48:4]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            roll_reg <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg <= yaw_next;
            thr_reg <= thr_next;
        end
        if (r2 && v1_reg)
        begin
            n_reg <= n_next;
        end
        if (r3 && v2_reg)
        begin
            x_reg <= x_next;
        end
    end

endmodule
`default_nettype wire

// File: src/qrmm_sqrt.sv
// Pipelined integer square root, two root bits per stage, four motor lanes.
`default_nettype none
module qrmm_sqrt
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire qrmm_pkg::rad_vec_t in_x,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output qrmm_pkg::root_vec_t     out_root
);

    localparam int N = qrmm_pkg::SQ_STAGES;

    logic                v_reg [N];
    logic                rdy [N+1];
    qrmm_pkg::sq_stage_t st_reg [N];
    qrmm_pkg::sq_stage_t st_in [N];
    qrmm_pkg::sq_stage_t st_next [N];
    logic                load [N];

    assign rdy[N] = out_ready;
    assign in_ready = rdy[0];
    assign out_valid = v_reg[N-1];
    assign out_root = st_reg[N-1].root;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        if (k > 0)
        begin : g_link
            assign st_in[k] = st_reg[k-1];
            assign load[k] = v_reg[k-1];
        end
        else
        begin : g_head
            assign st_in[k] = '{x: in_x, rem: '0, root: '0};
            assign load[k] = in_valid;
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb
        begin
            qrmm_pkg::sq_digit_t d0, d1;
            for (int i = 0; i < qrmm_pkg::MOTORS; i++)
            begin
                d0 = qrmm_pkg::sqrt_digit(st_in[k].rem[i], st_in[k].root[i],
                                          st_in[k].x[i][qrmm_pkg::RAD_W-1 -: 2]);
                d1 = qrmm_pkg::sqrt_digit(d0.rem, d0.root,
                                          st_in[k].x[i][qrmm_pkg::RAD_W-3 -: 2]);
                st_next[k].rem[i] = d1.rem;
                st_next[k].root[i] = d1.root;
                st_next[k].x[i] = {st_in[k].x[i][qrmm_pkg::RAD_W-5:0], 4'd0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= load[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && load[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

endmodule
`default_nettype wire

// File: src/qrmm_scale.sv
// Divide-by-49 duty scaling, trim addition and limit clamping stages.
`default_nettype none
module qrmm_scale
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [qrmm_pkg::DUTY_W-1:0]   duty_min,
    input  wire logic [qrmm_pkg::DUTY_W-1:0]   duty_max,
    input  wire qrmm_pkg::duty_vec_t           trim,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire qrmm_pkg::root_vec_t           in_root,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output qrmm_pkg::result_t                  out_result
);

    localparam int QW = qrmm_pkg::QUOT_W;

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    qrmm_pkg::root_vec_t                  s_reg;
    logic [qrmm_pkg::MOTORS-1:0][QW-1:0]  q0_reg, q0_next;
    logic [qrmm_pkg::MOTORS-1:0][QW:0]    sum_reg, sum_next;
    qrmm_pkg::result_t                    res_reg, res_next;

    assign r3 = !v3_reg || out_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;
    assign out_valid = v3_reg;
    assign out_result = res_reg;

    // Stage one: reciprocal estimate, at most one below the true quotient.
    always_comb
    begin
        for (int i = 0; i < qrmm_pkg::MOTORS; i++)
        begin
            logic [48:0] prod;
            prod = {25'd0, in_root[i]} * {24'd0, qrmm_pkg::RECIP_49};
            q0_next[i] = prod[qrmm_pkg::RECIP_SHIFT +: QW];
        end
    end

    // Stage two: correct the estimate and add the trim.
    always_comb
    begin
        for (int i = 0; i < qrmm_pkg::MOTORS; i++)
        begin
            logic [qrmm_pkg::ROOT_W-1:0] rmd;
            logic [QW-1:0]               q;
            rmd = s_reg[i] - qrmm_pkg::ROOT_W'(q0_reg[i] * qrmm_pkg::ROOT_DIV);
            q = (rmd >= qrmm_pkg::ROOT_DIV) ? q0_reg[i] + 1'b1 : q0_reg[i];
            sum_next[i] = {1'b0, q} + {3'd0, trim[i]};
        end
    end

    // Stage three: lower limit first, then upper limit.
    always_comb
    begin
        for (int i = 0; i < qrmm_pkg::MOTORS; i++)
        begin
            logic [QW:0] v;
            logic        hit;
            v = sum_reg[i];
            hit = 1'b0;
            if (v < {3'd0, duty_min})
            begin
                v = {3'd0, duty_min};
                hit = 1'b1;
            end
            if (v > {3'd0, duty_max})
            begin
                v = {3'd0, duty_max};
                hit = 1'b1;
            end
            res_next.duty[i] = v[qrmm_pkg::DUTY_W-1:0];
            res_next.clamped_mask[i] = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            s_reg <= in_root;
            q0_reg <= q0_next;
        end
        if (r2 && v1_reg)
        begin
            sum_reg <= sum_next;
        end
        if (r3 && v2_reg)
        begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

// File: src/quad_rotor_motor_mixer_top.sv
// Top level of the quadrotor X-frame motor mixer: configuration registers and pipeline.
//
// Channel     Direction  Handshake                    Content
// s_axis      in         s_axis_tvalid/s_axis_tready  roll, pitch, yaw, height commands
// m_axis      out        m_axis_tvalid/m_axis_tready  four motor duties, clamp flags
// cfg         in         cfg_valid/cfg_ready          register index and write data
//
// One command set enters per cycle while the output is not stalled, and passes
// three mixing stages, twelve square-root stages (two root bits each) and
// three scaling and clamping stages, the last of which is the output register.
// Every stage holds its own valid bit and moves whenever the stage after it
// is empty or moving, so a stalled output never drops or repeats a transfer
// and bubbles close up. Reset clears all valid bits and loads the register
// defaults; the configuration port is always ready.
`default_nettype none
module quad_rotor_motor_mixer_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // tdata: roll_command[15:0], pitch_command[31:16], yaw_command[47:32],
    // height_command[55:48]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,
    // tdata: duty_one[16:0], duty_two[33:17], duty_three[50:34],
    // duty_four[67:51], clamped_mask[71:68]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    logic [qrmm_pkg::DUTY_W-1:0] duty_min_reg, duty_max_reg;
    logic                        yaw_enable_reg, height_enable_reg;
    qrmm_pkg::duty_vec_t         trim_reg;

    qrmm_pkg::cmd_t      cmd;
    logic                mix_valid, mix_ready;
    qrmm_pkg::rad_vec_t  mix_x;
    logic                sq_valid, sq_ready;
    qrmm_pkg::root_vec_t sq_root;
    qrmm_pkg::result_t   result;

    assign cfg_ready = 1'b1;

    // Register writes; new settings should reach the block only while idle, which the block itself does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_min_reg <= qrmm_pkg::DUTY_MIN_RST;
            duty_max_reg <= qrmm_pkg::DUTY_MAX_RST;
            yaw_enable_reg <= 1'b0;
            height_enable_reg <= 1'b0;
            trim_reg[0] <= qrmm_pkg::TRIM_ONE_RST;
            trim_reg[1] <= qrmm_pkg::TRIM_TWO_RST;
            trim_reg[2] <= qrmm_pkg::TRIM_THREE_RST;
            trim_reg[3] <= qrmm_pkg::TRIM_FOUR_RST;
        end
        else if (cfg_valid)
        begin
            case (qrmm_pkg::cfg_index_t'(cfg_index))
                qrmm_pkg::REG_DUTY_MIN:      duty_min_reg <= cfg_data;
                qrmm_pkg::REG_DUTY_MAX:      duty_max_reg <= cfg_data;
                qrmm_pkg::REG_YAW_ENABLE:    yaw_enable_reg <= cfg_data[0];
                qrmm_pkg::REG_HEIGHT_ENABLE: height_enable_reg <= cfg_data[0];
                qrmm_pkg::REG_TRIM_ONE:      trim_reg[0] <= cfg_data;
                qrmm_pkg::REG_TRIM_TWO:      trim_reg[1] <= cfg_data;
                qrmm_pkg::REG_TRIM_THREE:    trim_reg[2] <= cfg_data;
                qrmm_pkg::REG_TRIM_FOUR:     trim_reg[3] <= cfg_data;
                default:                     duty_min_reg <= duty_min_reg;
            endcase
        end
    end

    assign cmd = s_axis_tdata;

    qrmm_mix u_mix
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .yaw_enable    (yaw_enable_reg),
        .height_enable (height_enable_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_cmd        (cmd),
        .out_valid     (mix_valid),
        .out_ready     (mix_ready),
        .out_x         (mix_x)
    );

    qrmm_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_x      (mix_x),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_root  (sq_root)
    );

    qrmm_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .duty_min   (duty_min_reg),
        .duty_max   (duty_max_reg),
        .trim       (trim_reg),
        .in_valid   (sq_valid),
        .in_ready   (sq_ready),
        .in_root    (sq_root),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // The result struct packs duties from motor one upward, then the mask.
    assign m_axis_tdata = result;

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the quadrotor motor mixer: directed and random commands, duty prediction.
`default_nettype none
module testbench;

    // Clock and reset.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #2 clk = ~clk;

    // Block ports. Every input starts at a known value.
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    quad_rotor_motor_mixer_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the configuration registers, kept in step with every write.
    logic [16:0] lim_min;
    logic [16:0] lim_max;
    logic        yaw_on;
    logic        height_on;
    logic [16:0] trims [4];

    // Commands waiting to be sent, and duty sets waiting to come out.
    qrmm_pkg::cmd_t cmd_pending [$];
    logic [71:0]    duty_expected [$];

    int  errors = 0;
    int  cycles = 0;
    bit  calm = 1'b0;      // when set, neither side idles
    int  src_gap = 0;
    int  snk_gap = 0;
    bit  cfg_busy = 1'b0;

    // Bitwise integer square root of a nonnegative 64-bit value.
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Mixes one command set through the X-frame matrix and predicts the packed duties.
    function automatic logic [71:0] mix_duties(input qrmm_pkg::cmd_t c);
        longint roll_t;
        longint pitch_t;
        longint yaw_t;
        longint hgt;
        longint thrust;
        longint rad;
        longint unsigned duty;
        logic [3:0]  mask;
        logic [71:0] packed_out;
        int sr [4];
        int sp [4];
        int sy [4];
        sr = '{1, 1, -1, -1};
        sp = '{1, -1, -1, 1};
        sy = '{1, -1, 1, -1};
        roll_t = longint'(c.roll_command) * 10240;
        pitch_t = longint'(c.pitch_command) * 10240;
        yaw_t = yaw_on ? longint'(c.yaw_command) * 163061 : 0;
        hgt = height_on ? longint'(c.height_command) : 0;
        thrust = 64'sd20422816 * (10 * hgt + 98);
        mask = '0;
        packed_out = '0;
        for (int m = 0; m < 4; m++)
        begin
            rad = thrust + sr[m] * roll_t + sp[m] * pitch_t + sy[m] * yaw_t;
            duty = trims[m];
            // A negative or zero radicand adds nothing instead of failing.
            if (rad > 0)
                duty = duty + int_sqrt((longint'(rad) * 250000) / 614656);
            if (duty < lim_min)
            begin
                duty = lim_min;
                mask[m] = 1'b1;
            end
            if (duty > lim_max)
            begin
                duty = lim_max;
                mask[m] = 1'b1;
            end
            packed_out[m*17 +: 17] = duty[16:0];
        end
        packed_out[71:68] = mask;
        return packed_out;
    endfunction

    // Driver: sends queued commands, with random bursts of idle cycles.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_pending.size() > 0)
                begin
                    duty_expected.push_back(mix_duties(cmd_pending[0]));
                    s_axis_tdata <= cmd_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        src_gap <= $urandom_range(1, 5);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each output transfer against the oldest prediction,
    // and applies random backpressure.
    always @(posedge clk)
    begin
        logic [71:0] want;
        logic        bad;
        bad = 1'b0;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (duty_expected.size() == 0)
                begin
                    $display("%0t: unexpected output %h", $time, m_axis_tdata);
                    bad = 1'b1;
                end
                else
                begin
                    want = duty_expected.pop_front();
                    for (int f = 0; f < 5; f++)
                    begin
                        if (f < 4 && want[f*17 +: 17] != m_axis_tdata[f*17 +: 17])
                        begin
                            $display("%0t: duty %0d expected %0d actual %0d", $time, f + 1,
                                     want[f*17 +: 17], m_axis_tdata[f*17 +: 17]);
                            bad = 1'b1;
                        end
                        if (f == 4 && want[71:68] != m_axis_tdata[71:68])
                        begin
                            $display("%0t: clamp mask expected %h actual %h", $time,
                                     want[71:68], m_axis_tdata[71:68]);
                            bad = 1'b1;
                        end
                    end
                end
            end
            if (bad)
                errors <= errors + 1;
            if (snk_gap > 0)
            begin
                snk_gap <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    snk_gap <= $urandom_range(1, 5);
            end
        end
    end

    // Writes one register through the configuration channel and mirrors it.
    task automatic write_reg(input qrmm_pkg::cfg_index_t idx, input logic [16:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            qrmm_pkg::REG_DUTY_MIN:      lim_min = val;
            qrmm_pkg::REG_DUTY_MAX:      lim_max = val;
            qrmm_pkg::REG_YAW_ENABLE:    yaw_on = val[0];
            qrmm_pkg::REG_HEIGHT_ENABLE: height_on = val[0];
            qrmm_pkg::REG_TRIM_ONE:      trims[0] = val;
            qrmm_pkg::REG_TRIM_TWO:      trims[1] = val;
            qrmm_pkg::REG_TRIM_THREE:    trims[2] = val;
            default:                     trims[3] = val;
        endcase
    endtask

    // Returns once every queued command has gone out and every result is back.
    task automatic drain();
        while (cmd_pending.size() > 0 || s_axis_tvalid || duty_expected.size() > 0)
            @(posedge clk);
    endtask

    // Random command set; one shape in four keeps roll, pitch and yaw small,
    // another keeps the height small, and the rest stay fully random.
    function automatic qrmm_pkg::cmd_t random_cmd();
        qrmm_pkg::cmd_t c;
        c = qrmm_pkg::cmd_t'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0:
            begin
                c.roll_command = 16'($signed($urandom_range(0, 2000)) - 1000);
                c.pitch_command = 16'($signed($urandom_range(0, 2000)) - 1000);
                c.yaw_command = 16'($signed($urandom_range(0, 200)) - 100);
            end
            1: c.height_command = 8'($signed($urandom_range(0, 20)) - 10);
            default: ;
        endcase
        return c;
    endfunction

    // Queues a burst of random commands.
    task automatic random_phase(input int count);
        for (int k = 0; k < count; k++)
            cmd_pending.push_back(random_cmd());
    endtask

    // Timeout guard: far beyond the slowest correct run.
    always @(posedge clk)
    begin
        if (cycles > 200000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        qrmm_pkg::cmd_t c;
        logic [15:0] ext [4];
        lim_min = qrmm_pkg::DUTY_MIN_RST;
        lim_max = qrmm_pkg::DUTY_MAX_RST;
        yaw_on = 1'b0;
        height_on = 1'b0;
        trims[0] = qrmm_pkg::TRIM_ONE_RST;
        trims[1] = qrmm_pkg::TRIM_TWO_RST;
        trims[2] = qrmm_pkg::TRIM_THREE_RST;
        trims[3] = qrmm_pkg::TRIM_FOUR_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset defaults, then again with yaw and height on:
        // extremes of every field, and radicands driven negative.
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        for (int p = 0; p < 2; p++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                c.roll_command = ext[k];
                c.pitch_command = ext[3 - k];
                c.yaw_command = ext[(k + 1) % 4];
                c.height_command = ext[k][15:8];
                cmd_pending.push_back(c);
            end
            c = '{height_command: 8'h80, yaw_command: 16'h8000,
                  pitch_command: 16'h0000, roll_command: 16'h0000};
            cmd_pending.push_back(c);
            c = '{height_command: 8'h7F, yaw_command: 16'h7FFF,
                  pitch_command: 16'h7FFF, roll_command: 16'h8000};
            cmd_pending.push_back(c);
            drain();
            if (p == 0)
            begin
                write_reg(qrmm_pkg::REG_YAW_ENABLE, 17'd1);
                write_reg(qrmm_pkg::REG_HEIGHT_ENABLE, 17'd1);
            end
        end

        random_phase(300);
        drain();
        // Wide limits with near-zero trims (0 to 3) so the square root itself shows.
        write_reg(qrmm_pkg::REG_DUTY_MIN, 17'd0);
        write_reg(qrmm_pkg::REG_DUTY_MAX, 17'h1FFFF);
        write_reg(qrmm_pkg::REG_TRIM_ONE, 17'd0);
        write_reg(qrmm_pkg::REG_TRIM_TWO, 17'd1);
        write_reg(qrmm_pkg::REG_TRIM_THREE, 17'd2);
        write_reg(qrmm_pkg::REG_TRIM_FOUR, 17'd3);
        random_phase(300);
        drain();
        // Large trims against the full-scale ceiling.
        write_reg(qrmm_pkg::REG_TRIM_ONE, 17'h1FFFF);
        write_reg(qrmm_pkg::REG_TRIM_FOUR, 17'h10000);
        write_reg(qrmm_pkg::REG_YAW_ENABLE, 17'd0);
        random_phase(250);
        drain();
        // Crossed limits: every duty becomes the maximum.
        write_reg(qrmm_pkg::REG_DUTY_MIN, 17'd100000);
        write_reg(qrmm_pkg::REG_DUTY_MAX, 17'd50000);
        write_reg(qrmm_pkg::REG_HEIGHT_ENABLE, 17'd0);
        random_phase(150);
        drain();
        // Random settings for the remainder; the last stretch runs with no idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(qrmm_pkg::REG_DUTY_MIN, 17'($urandom_range(40000, 70000)));
            write_reg(qrmm_pkg::REG_DUTY_MAX, 17'($urandom_range(70000, 131071)));
            write_reg(qrmm_pkg::REG_YAW_ENABLE, 17'($urandom_range(0, 1)));
            write_reg(qrmm_pkg::REG_HEIGHT_ENABLE, 17'($urandom_range(0, 1)));
            write_reg(qrmm_pkg::REG_TRIM_ONE, 17'($urandom_range(40000, 60000)));
            write_reg(qrmm_pkg::REG_TRIM_TWO, 17'($urandom_range(40000, 60000)));
            write_reg(qrmm_pkg::REG_TRIM_THREE, 17'($urandom_range(40000, 60000)));
            write_reg(qrmm_pkg::REG_TRIM_FOUR, 17'($urandom_range(40000, 60000)));
            if (ph == 3)
                calm = 1'b1;
            random_phase(160);
            drain();
        end

        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
